// File: rtl/bba_pkg.sv
// Shared constants and types of the bitmap block allocator.
// Used by the channel interfaces and by the top level; depends on nothing.
package bba_pkg;

	localparam int MaxBlocks       = 65536;
	localparam int BitsPerMapBlock = 4096;
	localparam int MapBytes        = MaxBlocks / 8;
	localparam int WordBits        = 64;
	localparam int LanesPerWord    = WordBits / 8;
	localparam int MapWords        = MapBytes / LanesPerWord;
	localparam int WordAw          = $clog2(MapWords);
	localparam int LaneAw          = $clog2(LanesPerWord);
	localparam int BitOffW         = $clog2(WordBits);
	localparam int ByteIdxW        = $clog2(MapBytes);
	localparam int BlockW          = $clog2(MaxBlocks);
	localparam int MapBlkShift     = $clog2(BitsPerMapBlock);
	localparam int CfgIdxW         = 1;
	localparam int CfgDataW        = 16;

	typedef enum logic [1:0] {
		MODE_LOAD  = 2'd0,
		MODE_READ  = 2'd1,
		MODE_ALLOC = 2'd2
	} mode_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_TOTAL_BLOCKS = 1'b0,
		REG_BITMAP_FIRST = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RDWAIT,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

// File: rtl/bba_if.sv
// Valid/ready channel interfaces of the bitmap block allocator.
// Depends on bba_pkg for the field widths.
interface bba_req_if import bba_pkg::*;;
	logic                valid;
	logic                ready;
	logic [1:0]          mode;
	logic [ByteIdxW-1:0] byte_index;
	logic [7:0]          byte_value;

	modport source (output valid, mode, byte_index, byte_value, input ready);
	modport sink   (input valid, mode, byte_index, byte_value, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*;;
	logic              valid;
	logic              ready;
	logic              status;
	logic [BlockW-1:0] allocated_block;
	logic [7:0]        read_byte;

	modport source (output valid, status, allocated_block, read_byte, input ready);
	modport sink   (input valid, status, allocated_block, read_byte, output ready);
endinterface

// File: rtl/bitmap_block_allocator.sv
// Top level of the bitmap block allocator: free-block bitmap memory and scan sequencer.
// Depends on bba_pkg and on the channel interfaces in bba_if.sv.
//
//  channel  dir  payload                                   transfer
//  req      in   mode, byte_index, byte_value              valid & ready
//  rsp      out  status, allocated_block, read_byte        valid & ready
//  cfg      in   cfg_index, cfg_wdata                      cfg_we
//
// A load, an unused mode or an empty allocation goes from idle straight to the final
// state, a read passes through a wait state for the memory, and a scanning allocation
// ends at a hit or the last word: it reads one 64-bit bitmap word per cycle from the memory.
// Reset clears the sequencer and output valid flag; the payloads and bitmap memory are not cleared.
// A new request is taken whenever the sequencer is idle, even while a result waits
// in the output register; a stalled output holds the sequencer in its final state.
module bitmap_block_allocator import bba_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_wdata,
	bba_req_if.sink             req,
	bba_rsp_if.source           rsp
);

	logic [WordBits-1:0] mem [MapWords];

	state_t state_q, state_d;

	logic [BlockW-1:0]   total_q, first_q;
	logic [WordAw-1:0]   scan_addr_q, first_word_q, last_word_q, w_s1;
	logic [BitOffW-1:0]  start_off_q, end_off_q;
	logic                issue_done_q, rdv_s1;
	logic [LaneAw-1:0]   lane_q;
	logic [WordBits-1:0] rdata_s1;

	logic                res_status_q;
	logic [BlockW-1:0]   res_block_q;
	logic [7:0]          res_byte_q;
	logic                out_valid_q, out_status_q;
	logic [BlockW-1:0]   out_block_q;
	logic [7:0]          out_byte_q;

	// Scan range of an allocation, worked out from the registers.
	logic [4:0]        map_blocks;
	logic [BlockW:0]   scan_start;
	logic              range_empty;
	logic [BlockW-1:0] scan_last;

	// Control of the current cycle.
	logic                accept, push;
	logic                mem_we;
	logic [WordAw-1:0]   mem_waddr, mem_raddr;
	logic [LaneAw-1:0]   mem_wlane;
	logic [7:0]          mem_wdata;

	// Hit search over the word returned by the memory.
	logic [WordBits-1:0] free_vec, lo_mask, hi_mask, cand;
	logic [BitOffW-1:0]  lo_off, hi_off, hit_off;
	logic                hit;
	logic [7:0]          hit_old_byte, hit_new_byte;
	logic                scan_end;

	assign map_blocks  = 5'(({1'b0, total_q} + 17'(BitsPerMapBlock - 1)) >> MapBlkShift);
	assign scan_start  = {1'b0, first_q} + 17'(map_blocks);
	assign range_empty = scan_start >= {1'b0, total_q};
	assign scan_last   = total_q - 16'd1;

	assign accept = req.valid && req.ready;
	assign push   = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);

	always_comb begin
		// Bit o of free_vec is the free flag of block (word base + o); MSB of a byte is lowest.
		for (int o = 0; o < WordBits; o++) begin
			free_vec[o] = rdata_s1[8 * (o / 8) + 7 - (o % 8)];
		end
		lo_off  = (w_s1 == first_word_q) ? start_off_q : '0;
		hi_off  = (w_s1 == last_word_q) ? end_off_q : '1;
		lo_mask = {WordBits{1'b1}} << lo_off;
		hi_mask = {WordBits{1'b1}} >> (BitOffW'(WordBits - 1) - hi_off);
		cand    = free_vec & lo_mask & hi_mask;
		hit     = |cand;
		hit_off = '0;
		for (int o = WordBits - 1; o >= 0; o--) begin
			if (cand[o]) begin
				hit_off = BitOffW'(o);
			end
		end
		hit_old_byte = rdata_s1[{hit_off[BitOffW-1:3], 3'b000} +: 8];
		hit_new_byte = hit_old_byte & ~(8'h80 >> hit_off[2:0]);
		scan_end     = rdv_s1 && (hit || (w_s1 == last_word_q));
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req.mode)
						MODE_READ:  state_d = ST_RDWAIT;
						MODE_ALLOC: state_d = range_empty ? ST_DONE : ST_SCAN;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_RDWAIT: state_d = ST_DONE;
			ST_SCAN: begin
				if (scan_end) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (push) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: request ready and memory port control.
	always_comb begin
		req.ready = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = req.byte_index[ByteIdxW-1:LaneAw];
		mem_wlane = req.byte_index[LaneAw-1:0];
		mem_wdata = req.byte_value;
		mem_raddr = req.byte_index[ByteIdxW-1:LaneAw];
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				mem_we    = req.valid && (req.mode == MODE_LOAD);
			end
			ST_SCAN: begin
				mem_raddr = scan_addr_q;
				mem_we    = rdv_s1 && hit;
				mem_waddr = w_s1;
				mem_wlane = hit_off[BitOffW-1:3];
				mem_wdata = hit_new_byte;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr][{mem_wlane, 3'b000} +: 8] <= mem_wdata;
		end
		rdata_s1 <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			total_q      <= 16'd280;
			first_q      <= 16'd6;
			rdv_s1       <= 1'b0;
			issue_done_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_TOTAL_BLOCKS: total_q <= cfg_wdata;
					REG_BITMAP_FIRST: first_q <= cfg_wdata;
					default: begin
					end
				endcase
			end
			if (accept) begin
				rdv_s1       <= 1'b0;
				issue_done_q <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				rdv_s1 <= !issue_done_q;
				if (!issue_done_q && (scan_addr_q == last_word_q)) begin
					issue_done_q <= 1'b1;
				end
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			lane_q       <= req.byte_index[LaneAw-1:0];
			scan_addr_q  <= scan_start[BlockW-1:BitOffW];
			first_word_q <= scan_start[BlockW-1:BitOffW];
			start_off_q  <= scan_start[BitOffW-1:0];
			last_word_q  <= scan_last[BlockW-1:BitOffW];
			end_off_q    <= scan_last[BitOffW-1:0];
			res_status_q <= (req.mode == MODE_ALLOC) && range_empty;
			res_block_q  <= '0;
			res_byte_q   <= '0;
		end else begin
			case (state_q)
				ST_RDWAIT: res_byte_q <= rdata_s1[{lane_q, 3'b000} +: 8];
				ST_SCAN: begin
					w_s1 <= scan_addr_q;
					if (!issue_done_q) begin
						scan_addr_q <= scan_addr_q + 1'b1;
					end
					if (scan_end) begin
						if (hit) begin
							res_block_q <= {w_s1, hit_off};
						end else begin
							res_status_q <= 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
		if (push) begin
			out_status_q <= res_status_q;
			out_block_q  <= res_block_q;
			out_byte_q   <= res_byte_q;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.status          = out_status_q;
	assign rsp.allocated_block = out_block_q;
	assign rsp.read_byte       = out_byte_q;

	// A word under test always lies inside the scan range.
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && rdv_s1) |-> (w_s1 >= first_word_q && w_s1 <= last_word_q))
		else $error("scan word outside range");

	// The scan writes back at most once and then finishes.
	a_single_writeback: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && mem_we) |=> (state_q == ST_DONE))
		else $error("scan continued after write-back");

	// A failed allocation carries no block and no byte.
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status) |-> (rsp.allocated_block == '0 && rsp.read_byte == '0))
		else $error("failed allocation with payload");

	// An allocated block lies below the volume size.
	a_block_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.allocated_block != '0) |-> (rsp.allocated_block < total_q))
		else $error("allocated block beyond volume");

endmodule
